>>> rtl/core/steq_pkg.sv
package steq_pkg;

    // operation codes on the input channel
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // status codes on the result channel
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // width of the reported entry count
    localparam int COUNT_OUT_BITS = 6;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // action applied to the cell row
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_POP    = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_act;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       exec;
        t_act       act;
        logic [1:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
    } t_dp_stat;

endpackage

>>> rtl/core/steq_ctrl.sv
module steq_ctrl
    import steq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        // decode the latched operation into a cell row action and a status code
        o_cmd.act    = ACT_NONE;
        o_cmd.status = ST_OK;
        case (i_stat.op)
            OP_INSERT: begin
                if (i_stat.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.act = ACT_INSERT;
                end
            end
            OP_POP: begin
                if (i_stat.empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.act = ACT_POP;
                end
            end
            OP_CLEAR: o_cmd.act = ACT_CLEAR;
            default:  o_cmd.act = ACT_NONE;
        endcase

        // sequencing: capture on transfer, execute once the result slot is free
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a result is never written over one that is still waiting
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    // a captured item is in the execute state in the following cycle
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("captured item not in execute");

    // every execution presents a result
    a_exec_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("execution without result");

    // no full insert or empty pop reaches the cell row
    a_act_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !((o_cmd.act == ACT_INSERT && i_stat.full) ||
                         (o_cmd.act == ACT_POP && i_stat.empty)))
        else $error("illegal cell row action");

endmodule

>>> rtl/core/steq_datapath.sv
module steq_datapath
    import steq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 32,
    parameter int TAG_BITS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [1:0]                i_operation,
    input  logic [TIME_BITS-1:0]      i_start_time,
    input  logic [TAG_BITS-1:0]       i_event_tag,
    output logic [1:0]                o_status,
    output logic [TIME_BITS-1:0]      o_popped_time,
    output logic [TAG_BITS-1:0]       o_popped_tag,
    output logic [COUNT_OUT_BITS-1:0] o_entry_count
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]           r_op;
    logic [TIME_BITS-1:0] r_key;
    logic [TAG_BITS-1:0]  r_tag;
    logic [CNT_BITS-1:0]  r_count, n_count;

    logic [TIME_BITS-1:0] r_time [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  r_etag [QUEUE_DEPTH];

    logic [1:0]           r_res_status;
    logic [TIME_BITS-1:0] r_res_time;
    logic [TAG_BITS-1:0]  r_res_tag;
    logic [CNT_BITS-1:0]  r_res_count;

    // per cell: occupied and not later than the new key
    logic [QUEUE_DEPTH-1:0] le;

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= i_start_time;
            r_tag <= i_event_tag;
        end
    end

    assign o_stat.op    = r_op;
    assign o_stat.full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // cell row: each cell keeps, takes the new event, or shifts
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                 left_le;
        logic [TIME_BITS-1:0] up_time, dn_time;
        logic [TAG_BITS-1:0]  up_tag, dn_tag;

        assign le[g] = (CNT_BITS'(g) < r_count) && (r_time[g] <= r_key);

        if (g == 0) begin : g_first
            assign left_le = 1'b1;
            assign up_time = r_key;
            assign up_tag  = r_tag;
        end else begin : g_mid
            assign left_le = le[g-1];
            assign up_time = r_time[g-1];
            assign up_tag  = r_etag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign dn_time = r_time[g];
            assign dn_tag  = r_etag[g];
        end else begin : g_inner
            assign dn_time = r_time[g+1];
            assign dn_tag  = r_etag[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                case (i_cmd.act)
                    ACT_INSERT: begin
                        if (!le[g]) begin
                            if (left_le) begin
                                r_time[g] <= r_key;
                                r_etag[g] <= r_tag;
                            end else begin
                                r_time[g] <= up_time;
                                r_etag[g] <= up_tag;
                            end
                        end
                    end
                    ACT_POP: begin
                        r_time[g] <= dn_time;
                        r_etag[g] <= dn_tag;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // occupancy update
    always_comb begin
        case (i_cmd.act)
            ACT_INSERT: n_count = r_count + CNT_BITS'(1);
            ACT_POP:    n_count = r_count - CNT_BITS'(1);
            ACT_CLEAR:  n_count = '0;
            default:    n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= i_cmd.status;
            r_res_count  <= n_count;
            if (i_cmd.act == ACT_POP) begin
                r_res_time <= r_time[0];
                r_res_tag  <= r_etag[0];
            end else begin
                r_res_time <= '0;
                r_res_tag  <= '0;
            end
        end
    end

    assign o_status      = r_res_status;
    assign o_popped_time = r_res_time;
    assign o_popped_tag  = r_res_tag;
    assign o_entry_count = COUNT_OUT_BITS'(r_res_count);

endmodule

>>> rtl/core/stable_time_ordered_event_queue.sv
// Sequencing: an item is captured on the input transfer and executed in the
//   controller's execute state, which writes the result register; execution
//   waits while an earlier result is still stalled at the output. No new item
//   is taken until the last one has executed; the cell row compares and shifts in the execute step.
// Reset (synchronous, active low) empties the queue and the output register;
//   the cell contents are not cleared and there is no clearing pass.
module stable_time_ordered_event_queue
    import steq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 32,
    parameter int TAG_BITS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [TIME_BITS-1:0]      i_start_time,
    input  logic [TAG_BITS-1:0]       i_event_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [TIME_BITS-1:0]      o_popped_time,
    output logic [TAG_BITS-1:0]       o_popped_tag,
    output logic [COUNT_OUT_BITS-1:0] o_entry_count
);

    t_cmd     cmd;
    t_dp_stat stat;

    // sequencing
    steq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // sorted cell row and result register
    steq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_start_time  (i_start_time),
        .i_event_tag   (i_event_tag),
        .o_status      (o_status),
        .o_popped_time (o_popped_time),
        .o_popped_tag  (o_popped_tag),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> bench/tb_stable_time_ordered_event_queue.sv
module tb_stable_time_ordered_event_queue
    import steq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] TAG_MAX = 16'hFFFF;

    // one result transfer, as predicted
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ptime;
        logic [15:0] ptag;
        logic [5:0]  count;
    } t_queue_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_INSERT;
    logic [31:0] start_time = '0;
    logic [15:0] event_tag = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] popped_time;
    logic [15:0] popped_tag;
    logic [5:0]  entry_count;

    // shadow copy of the queue contents
    logic [31:0] sched_times [DEPTH];
    logic [15:0] sched_tags [DEPTH];
    int          sched_count = 0;

    t_queue_result pending_results [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_trigger = 0;

    stable_time_ordered_event_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_start_time  (start_time),
        .i_event_tag   (event_tag),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_popped_time (popped_time),
        .o_popped_tag  (popped_tag),
        .o_entry_count (entry_count)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // apply one operation to the shadow queue and return the result it causes
    function automatic t_queue_result apply_queue_op(input logic [1:0] op,
                                                     input logic [31:0] t,
                                                     input logic [15:0] tag);
        t_queue_result r;
        int pos;
        int i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (sched_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // stable: land after every entry with an equal or earlier time
                    pos = 0;
                    while (pos < sched_count && sched_times[pos] <= t) pos++;
                    for (i = sched_count; i > pos; i--) begin
                        sched_times[i] = sched_times[i-1];
                        sched_tags[i] = sched_tags[i-1];
                    end
                    sched_times[pos] = t;
                    sched_tags[pos] = tag;
                    sched_count++;
                end
            end
            OP_POP: begin
                if (sched_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.ptime = sched_times[0];
                    r.ptag = sched_tags[0];
                    for (i = 1; i < sched_count; i++) begin
                        sched_times[i-1] = sched_times[i];
                        sched_tags[i-1] = sched_tags[i];
                    end
                    sched_count--;
                end
            end
            OP_CLEAR: begin
                sched_count = 0;
            end
            default: begin
            end
        endcase
        r.count = sched_count[5:0];
        return r;
    endfunction

    // offer one item, hold it until the transfer, then record its result
    task automatic send_item(input logic [1:0] op, input logic [31:0] t,
                             input logic [15:0] tag);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        start_time <= t;
        event_tag <= tag;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_results.push_back(apply_queue_op(op, t, tag));
    endtask

    // sender goes quiet until every expected result has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // key mix: many ties, some extremes, the rest full range
    function automatic logic [31:0] random_time();
        int k;
        k = $urandom_range(9);
        if (k < 4) return 32'($urandom_range(7));
        if (k == 4) return $urandom_range(1) ? TIME_MAX : 32'd0;
        return $urandom;
    endfunction

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin : receiver
        int hold_seen;
        int hold_left;
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_queue_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d time=%0h tag=%0h count=%0d",
                         $time, status, popped_time, popped_tag, entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (popped_time !== want.ptime) begin
                    $display("%0t: popped_time expected %0h actual %0h",
                             $time, want.ptime, popped_time);
                    error_count++;
                end
                if (popped_tag !== want.ptag) begin
                    $display("%0t: popped_tag expected %0h actual %0h",
                             $time, want.ptag, popped_tag);
                    error_count++;
                end
                if (entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, entry_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("tb_stable_time_ordered_event_queue: done, errors");
        $finish;
    end

    // edge cases: empty pop, ties, extreme keys and tags, clear, unused code
    task automatic test_directed();
        send_item(OP_POP, TIME_MAX, TAG_MAX);
        send_item(OP_INSERT, 32'd100, 16'd1);
        send_item(OP_INSERT, 32'd100, 16'd2);
        send_item(OP_INSERT, 32'd0, TAG_MAX);
        send_item(OP_INSERT, TIME_MAX, 16'd0);
        send_item(OP_INSERT, 32'd50, 16'd3);
        send_item(OP_INSERT, 32'd100, 16'd4);
        send_item(OP_UNUSED, TIME_MAX, TAG_MAX);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_CLEAR, 32'hA5A5_5A5A, 16'h5A5A);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_CLEAR, 32'd0, 16'd0);
        send_item(OP_INSERT, TIME_MAX, TAG_MAX);
        send_item(OP_INSERT, 32'd0, 16'd0);
        send_item(OP_INSERT, TIME_MAX, 16'd7);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_POP, 32'd0, 16'd0);
        send_item(OP_POP, 32'd0, 16'd0);
        wait_results_drained();
    endtask

    // fill past capacity while the receiver holds off, then drain past empty
    task automatic test_fill_and_overflow();
        int n;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = HOLD_OFF_CYCLES;
        hold_trigger++;
        for (n = 0; n < DEPTH + 2; n++) begin
            send_item(OP_INSERT, random_time(), 16'($urandom));
        end
        for (n = 0; n < DEPTH + 1; n++) begin
            send_item(OP_POP, $urandom, 16'($urandom));
        end
        wait_results_drained();
    endtask

    // random traffic drifting between filling, draining and balanced stretches
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int n;
        int r;
        int insert_pct;
        logic [1:0] op;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        insert_pct = 47;
        for (n = 0; n < count; n++) begin
            if (n % 48 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 66;
                    1: insert_pct = 30;
                    default: insert_pct = 47;
                endcase
            end
            r = $urandom_range(99);
            if (r < 2) op = OP_CLEAR;
            else if (r < 4) op = OP_UNUSED;
            else if (r < 4 + insert_pct) op = OP_INSERT;
            else op = OP_POP;
            send_item(op, random_time(), 16'($urandom));
        end
        wait_results_drained();
    endtask

    // stimulus sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_overflow();
        test_random_traffic(500, 0, 0);
        test_random_traffic(500, 74, 0);
        test_random_traffic(500, 0, 74);
        test_random_traffic(500, 31, 31);
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_stable_time_ordered_event_queue: done, clean");
        end else begin
            $display("tb_stable_time_ordered_event_queue: done, errors");
        end
        $finish;
    end

endmodule
